/* rtl/core/cct_pkg.sv */
// ============================================================================
// cct_pkg
// Shared widths, codes, types and reset values for the console cursor tracker.
// ============================================================================
package cct_pkg;

    localparam int COORD_BITS  = 12;
    localparam int GLYPH_W     = 21;
    localparam int GW_W        = 8;
    localparam int LH_W        = 8;
    localparam int SW_W        = 8;
    localparam int SCROLL_SHL  = 3;
    localparam int SHIFT_W     = LH_W + SCROLL_SHL;
    localparam int TAB_SHL     = 3;
    localparam int TAB_SPACES  = 8;
    localparam int TAB_SPAN_W  = SW_W + TAB_SHL;
    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [ACT_W-1:0] ACT_SCROLL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DRAW   = 2'd2;

    localparam logic [GLYPH_W-1:0] CH_NUL = 21'd0;
    localparam logic [GLYPH_W-1:0] CH_BS  = 21'd8;
    localparam logic [GLYPH_W-1:0] CH_TAB = 21'd9;
    localparam logic [GLYPH_W-1:0] CH_LF  = 21'd10;
    localparam logic [GLYPH_W-1:0] CH_CR  = 21'd13;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH = 3'd5;

    localparam logic [COORD_BITS-1:0] RST_WIN_LEFT    = 12'd109;
    localparam logic [COORD_BITS-1:0] RST_WIN_RIGHT   = 12'd1088;
    localparam logic [COORD_BITS-1:0] RST_WIN_TOP     = 12'd131;
    localparam logic [COORD_BITS-1:0] RST_WIN_BOTTOM  = 12'd1091;
    localparam logic [LH_W-1:0]       RST_LINE_HEIGHT = 8'd16;
    localparam logic [SW_W-1:0]       RST_SPACE_WIDTH = 8'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NEWLINE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_TAB_MUL,
        ST_TAB_EMIT,
        ST_CHR_EMIT,
        ST_BS_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_NL,
        KIND_TAB,
        KIND_CHR
    } kind_t;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [COORD_BITS-1:0] rect_left;
        logic [COORD_BITS-1:0] rect_top;
        logic [COORD_BITS-1:0] rect_right;
        logic [COORD_BITS-1:0] rect_bottom;
        logic [SHIFT_W-1:0]    scroll_shift;
        logic [GLYPH_W-1:0]    draw_code;
        logic                  last;
    } cmd_t;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] dividend;
        logic [SW_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/cct_char_if.sv */
// ============================================================================
// cct_char_if
// Input channel: one character code and its glyph width per word.
// ============================================================================
interface cct_char_if;
    logic                        valid;
    logic                        ready;
    logic [cct_pkg::GLYPH_W-1:0] glyph;
    logic [cct_pkg::GW_W-1:0]    glyph_width;

    modport source (output valid, output glyph, output glyph_width, input ready);
    modport sink   (input valid, input glyph, input glyph_width, output ready);
endinterface

/* rtl/core/cct_cmd_if.sv */
// ============================================================================
// cct_cmd_if
// Output channel: one drawing command per word.
// ============================================================================
interface cct_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [cct_pkg::ACT_W-1:0]      action;
    logic [cct_pkg::COORD_BITS-1:0] rect_left;
    logic [cct_pkg::COORD_BITS-1:0] rect_top;
    logic [cct_pkg::COORD_BITS-1:0] rect_right;
    logic [cct_pkg::COORD_BITS-1:0] rect_bottom;
    logic [cct_pkg::SHIFT_W-1:0]    scroll_shift;
    logic [cct_pkg::GLYPH_W-1:0]    draw_code;
    logic                           last;

    modport source (
        output valid, output action, output rect_left, output rect_top,
        output rect_right, output rect_bottom, output scroll_shift,
        output draw_code, output last, input ready
    );
    modport sink (
        input valid, input action, input rect_left, input rect_top,
        input rect_right, input rect_bottom, input scroll_shift,
        input draw_code, input last, output ready
    );
endinterface

/* rtl/core/console_cursor_tracker.sv */
// ============================================================================
// console_cursor_tracker
// Return, NUL and backspace on an empty stack go back to idle, backspace and
// printable characters to an emit state, newline to its own state, tab through
// a 12-step serial divide for the tab stop; a wrap passes the newline state first
// and a stalled command word holds the FSM. Commands leave through an output
// register; the next character is taken while the last command waits. Reset is
// asynchronous: cursor at the window origin, stack empty, stack memory left as is.
// ============================================================================
module console_cursor_tracker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0]   cfg_data,
    cct_char_if.sink                         char_in,
    cct_cmd_if.source                        cmd_out
);

    localparam int C     = cct_pkg::COORD_BITS;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [C-1:0]                   win_left_reg, win_right_reg;
    logic [C-1:0]                   win_top_reg, win_bottom_reg;
    logic [cct_pkg::LH_W-1:0]       line_height_reg;
    logic [cct_pkg::SW_W-1:0]       space_width_reg;

    cct_pkg::state_t                state_reg, state_next;
    cct_pkg::kind_t                 kind_reg, kind_next;
    logic [C-1:0]                   x_reg, x_next;
    logic [C-1:0]                   y_reg, y_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [cct_pkg::GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic [cct_pkg::GW_W-1:0]       gw_reg, gw_next;
    logic [cct_pkg::TAB_SPAN_W-1:0] adv_reg, adv_next;
    cct_pkg::cmd_t                  cmd_reg, cmd_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [C-1:0]                   ram_rdata;
    cct_pkg::div_req_t              div_req;
    cct_pkg::div_rsp_t              div_rsp;

    logic                           in_accept, out_free;
    logic [cct_pkg::SW_W-1:0]       tab_w;
    logic [cct_pkg::TAB_SPAN_W-1:0] tab_span;
    logic [cct_pkg::SHIFT_W-1:0]    shift;
    logic [C-1:0]                   y_plus_lh;
    logic                           nl_scroll, tab_wrap, chr_wrap;
    logic                           can_push;
    logic [CNT_W-1:0]               cnt_dec;
    logic [3:0]                     tab_k;
    logic [11:0]                    tab_prod;

    assign in_accept = char_in.valid && char_in.ready;
    assign out_free  = !out_valid_reg || cmd_out.ready;
    assign tab_w     = (space_width_reg == '0) ? cct_pkg::SW_W'(1) : space_width_reg;
    assign tab_span  = {tab_w, 3'b000};
    assign shift     = {line_height_reg, 3'b000};
    assign y_plus_lh = y_reg + C'(line_height_reg);
    assign nl_scroll = ({1'b0, y_reg} + (C + 1)'(line_height_reg)) >= {1'b0, win_bottom_reg};
    assign tab_wrap  = ({1'b0, x_reg} + (C + 1)'(tab_span)) >= {1'b0, win_right_reg};
    assign chr_wrap  = ({1'b0, x_reg} + (C + 1)'(gw_reg)) >= {1'b0, win_right_reg};
    assign can_push  = count_reg < CNT_W'(STACK_DEPTH);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign tab_k     = 4'(cct_pkg::TAB_SPACES) - {1'b0, div_rsp.quotient[2:0]};
    assign tab_prod  = {8'd0, tab_k} * {4'd0, tab_w};

    assign ram_waddr = count_reg[AW-1:0];
    assign ram_raddr = cnt_dec[AW-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg    <= cct_pkg::RST_WIN_LEFT;
            win_right_reg   <= cct_pkg::RST_WIN_RIGHT;
            win_top_reg     <= cct_pkg::RST_WIN_TOP;
            win_bottom_reg  <= cct_pkg::RST_WIN_BOTTOM;
            line_height_reg <= cct_pkg::RST_LINE_HEIGHT;
            space_width_reg <= cct_pkg::RST_SPACE_WIDTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cct_pkg::CFG_WIN_LEFT:    win_left_reg    <= cfg_data[C-1:0];
                cct_pkg::CFG_WIN_RIGHT:   win_right_reg   <= cfg_data[C-1:0];
                cct_pkg::CFG_WIN_TOP:     win_top_reg     <= cfg_data[C-1:0];
                cct_pkg::CFG_WIN_BOTTOM:  win_bottom_reg  <= cfg_data[C-1:0];
                cct_pkg::CFG_LINE_HEIGHT: line_height_reg <= cfg_data[cct_pkg::LH_W-1:0];
                cct_pkg::CFG_SPACE_WIDTH: space_width_reg <= cfg_data[cct_pkg::SW_W-1:0];
                default:                  ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cct_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = cct_pkg::ST_DECODE;
                end
            end
            cct_pkg::ST_DECODE:
            begin
                unique case (glyph_reg)
                    cct_pkg::CH_LF:  state_next = cct_pkg::ST_NEWLINE;
                    cct_pkg::CH_CR:  state_next = cct_pkg::ST_IDLE;
                    cct_pkg::CH_NUL: state_next = cct_pkg::ST_IDLE;
                    cct_pkg::CH_TAB:
                        state_next = tab_wrap ? cct_pkg::ST_NEWLINE : cct_pkg::ST_DIV_START;
                    cct_pkg::CH_BS:
                        state_next = (count_reg != '0) ? cct_pkg::ST_BS_EMIT : cct_pkg::ST_IDLE;
                    default:
                        state_next = chr_wrap ? cct_pkg::ST_NEWLINE : cct_pkg::ST_CHR_EMIT;
                endcase
            end
            cct_pkg::ST_NEWLINE:
            begin
                if (!nl_scroll || out_free)
                begin
                    unique case (kind_reg)
                        cct_pkg::KIND_TAB: state_next = cct_pkg::ST_DIV_START;
                        cct_pkg::KIND_CHR: state_next = cct_pkg::ST_CHR_EMIT;
                        default:           state_next = cct_pkg::ST_IDLE;
                    endcase
                end
            end
            cct_pkg::ST_DIV_START: state_next = cct_pkg::ST_DIV_WAIT;
            cct_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = cct_pkg::ST_TAB_MUL;
                end
            end
            cct_pkg::ST_TAB_MUL: state_next = cct_pkg::ST_TAB_EMIT;
            cct_pkg::ST_TAB_EMIT,
            cct_pkg::ST_CHR_EMIT,
            cct_pkg::ST_BS_EMIT:
            begin
                if (out_free)
                begin
                    state_next = cct_pkg::ST_IDLE;
                end
            end
            default: state_next = cct_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next        = kind_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        count_next       = count_reg;
        glyph_next       = glyph_reg;
        gw_next          = gw_reg;
        adv_next         = adv_reg;
        cmd_next         = cmd_reg;
        out_valid_next   = out_valid_reg && !cmd_out.ready;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = x_reg - win_left_reg;
        div_req.divisor  = tab_w;

        unique case (state_reg)
            cct_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    glyph_next = char_in.glyph;
                    gw_next    = char_in.glyph_width;
                    if (!can_push)
                    begin
                        count_next = '0;
                    end
                end
            end
            cct_pkg::ST_DECODE:
            begin
                unique case (glyph_reg)
                    cct_pkg::CH_LF:  kind_next = cct_pkg::KIND_NL;
                    cct_pkg::CH_TAB: kind_next = cct_pkg::KIND_TAB;
                    default:         kind_next = cct_pkg::KIND_CHR;
                endcase
                if (glyph_reg == cct_pkg::CH_CR)
                begin
                    count_next = '0;
                    x_next     = win_left_reg;
                end
                if (glyph_reg == cct_pkg::CH_BS && count_reg != '0)
                begin
                    count_next = cnt_dec;
                    ram_re     = 1'b1;
                end
            end
            cct_pkg::ST_NEWLINE:
            begin
                if (nl_scroll)
                begin
                    if (out_free)
                    begin
                        out_valid_next        = 1'b1;
                        cmd_next.action       = cct_pkg::ACT_SCROLL;
                        cmd_next.rect_left    = win_left_reg;
                        cmd_next.rect_top     = win_bottom_reg - C'(shift);
                        cmd_next.rect_right   = win_right_reg;
                        cmd_next.rect_bottom  = win_bottom_reg;
                        cmd_next.scroll_shift = shift;
                        cmd_next.draw_code    = '0;
                        cmd_next.last         = (kind_reg == cct_pkg::KIND_NL);
                        y_next                = y_reg - C'(shift) + C'(line_height_reg);
                        x_next                = win_left_reg;
                        count_next            = '0;
                    end
                end
                else
                begin
                    y_next     = y_plus_lh;
                    x_next     = win_left_reg;
                    count_next = '0;
                end
            end
            cct_pkg::ST_DIV_START:
            begin
                div_req.start = 1'b1;
            end
            cct_pkg::ST_DIV_WAIT: ;
            cct_pkg::ST_TAB_MUL:
            begin
                adv_next = tab_prod[cct_pkg::TAB_SPAN_W-1:0];
            end
            cct_pkg::ST_TAB_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    cmd_next.action       = cct_pkg::ACT_CLEAR;
                    cmd_next.rect_left    = x_reg;
                    cmd_next.rect_top     = y_reg;
                    cmd_next.rect_right   = x_reg + C'(adv_reg);
                    cmd_next.rect_bottom  = y_plus_lh;
                    cmd_next.scroll_shift = '0;
                    cmd_next.draw_code    = '0;
                    cmd_next.last         = 1'b1;
                    x_next                = x_reg + C'(adv_reg);
                    if (can_push)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            cct_pkg::ST_CHR_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    cmd_next.action       = cct_pkg::ACT_DRAW;
                    cmd_next.rect_left    = x_reg;
                    cmd_next.rect_top     = y_reg;
                    cmd_next.rect_right   = x_reg + C'(gw_reg);
                    cmd_next.rect_bottom  = y_plus_lh;
                    cmd_next.scroll_shift = '0;
                    cmd_next.draw_code    = glyph_reg;
                    cmd_next.last         = 1'b1;
                    x_next                = x_reg + C'(gw_reg);
                    if (can_push)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            cct_pkg::ST_BS_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    cmd_next.action       = cct_pkg::ACT_CLEAR;
                    cmd_next.rect_left    = ram_rdata;
                    cmd_next.rect_top     = y_reg;
                    cmd_next.rect_right   = x_reg;
                    cmd_next.rect_bottom  = y_plus_lh;
                    cmd_next.scroll_shift = '0;
                    cmd_next.draw_code    = '0;
                    cmd_next.last         = 1'b1;
                    x_next                = ram_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cct_pkg::ST_IDLE;
            kind_reg      <= cct_pkg::KIND_NL;
            x_reg         <= cct_pkg::RST_WIN_LEFT;
            y_reg         <= cct_pkg::RST_WIN_TOP;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        gw_reg    <= gw_next;
        adv_reg   <= adv_next;
        cmd_reg   <= cmd_next;
    end

    cct_ram #(
        .WIDTH (C),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (x_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cct_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign char_in.ready        = (state_reg == cct_pkg::ST_IDLE);
    assign cmd_out.valid        = out_valid_reg;
    assign cmd_out.action       = cmd_reg.action;
    assign cmd_out.rect_left    = cmd_reg.rect_left;
    assign cmd_out.rect_top     = cmd_reg.rect_top;
    assign cmd_out.rect_right   = cmd_reg.rect_right;
    assign cmd_out.rect_bottom  = cmd_reg.rect_bottom;
    assign cmd_out.scroll_shift = cmd_reg.scroll_shift;
    assign cmd_out.draw_code    = cmd_reg.draw_code;
    assign cmd_out.last         = cmd_reg.last;

endmodule

/* rtl/core/cct_ram.sv */
// ============================================================================
// cct_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cct_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/cct_div.sv */
// ============================================================================
// cct_div
// Restoring divider, one quotient bit per cycle, for the tab stop offset.
// ============================================================================
module cct_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cct_pkg::div_req_t req,
    output cct_pkg::div_rsp_t rsp
);

    localparam int C     = cct_pkg::COORD_BITS;
    localparam int DW    = cct_pkg::SW_W;
    localparam int CNT_W = $clog2(C + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [C-1:0]     quo_reg, quo_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[C-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(C);
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[C-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[C-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/core/cct_checker.sv */
// ============================================================================
// cct_checker
// Port-level checks on the console cursor tracker, bound to the top level.
// ============================================================================
module cct_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cct_pkg::ACT_W-1:0]    action,
    input logic [cct_pkg::SHIFT_W-1:0]  scroll_shift,
    input logic [cct_pkg::GLYPH_W-1:0]  draw_code,
    input logic                         last
);

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input ready right after an accepted word");

    a_action_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (action == cct_pkg::ACT_SCROLL || action == cct_pkg::ACT_CLEAR
                       || action == cct_pkg::ACT_DRAW)
    ) else $error("undefined action code");

    a_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && action != cct_pkg::ACT_DRAW && action != cct_pkg::ACT_SCROLL)
            |-> (draw_code == '0 && scroll_shift == '0)
    ) else $error("clear command carries draw code or scroll shift");

    a_stall_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(action) && $stable(draw_code) && $stable(last))
    ) else $error("stalled command word changed");

endmodule

bind console_cursor_tracker cct_checker u_cct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (char_in.valid),
    .in_ready     (char_in.ready),
    .out_valid    (cmd_out.valid),
    .out_ready    (cmd_out.ready),
    .action       (cmd_out.action),
    .scroll_shift (cmd_out.scroll_shift),
    .draw_code    (cmd_out.draw_code),
    .last         (cmd_out.last)
);
